/* sv/rsu_pkg.sv */
package rsu_pkg;

    // Coordinate width of every edge on the ports and inside the block.
    localparam int COORD_BITS = 16;

    // Number of surrounding pieces around the intersection.
    localparam int NUM_PIECES = 8;
    localparam int PIECE_IDX_BITS = $clog2(NUM_PIECES);

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CUT_LEFT   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CUT_TOP    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CUT_RIGHT  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CUT_BOTTOM = 2'd3;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // One classified item: the column edges, the row edges, the pieces to emit.
    // Column c spans xs[c] to xs[c+1]; row r spans ys[r] to ys[r+1].
    typedef struct packed {
        coord_t [3:0]            xs;
        coord_t [3:0]            ys;
        logic [NUM_PIECES-1:0]   mask;
        logic                    overlapped;
    } rsu_entry_t;

    // Column of each piece in emission order.
    function automatic logic [1:0] piece_col(input logic [PIECE_IDX_BITS-1:0] p);
        logic [1:0] c;
        case (p)
            3'd0, 3'd3, 3'd5: c = 2'd0;
            3'd1, 3'd6:       c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

    // Row of each piece in emission order.
    function automatic logic [1:0] piece_row(input logic [PIECE_IDX_BITS-1:0] p);
        logic [1:0] r;
        case (p)
            3'd0, 3'd1, 3'd2: r = 2'd0;
            3'd3, 3'd4:       r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

endpackage

/* sv/rsu_front.sv */
module rsu_front
    import rsu_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]   cfg_wdata,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  coord_t                  in_left,
    input  coord_t                  in_top,
    input  coord_t                  in_right,
    input  coord_t                  in_bottom,
    output logic                    ent_valid,
    input  logic                    ent_ready,
    output rsu_entry_t              ent
);

    coord_t     cut_left_reg;
    coord_t     cut_top_reg;
    coord_t     cut_right_reg;
    coord_t     cut_bottom_reg;
    logic       ent_valid_reg;
    rsu_entry_t ent_reg;

    coord_t     il;
    coord_t     it;
    coord_t     ir;
    coord_t     ib;
    logic       pass;
    logic [2:0] col_ne;
    logic [2:0] row_ne;
    logic       covered;
    rsu_entry_t ent_next;

    // Cut rectangle registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cut_left_reg   <= '0;
            cut_top_reg    <= '0;
            cut_right_reg  <= '0;
            cut_bottom_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CUT_LEFT:   cut_left_reg   <= cfg_wdata;
                CFG_CUT_TOP:    cut_top_reg    <= cfg_wdata;
                CFG_CUT_RIGHT:  cut_right_reg  <= cfg_wdata;
                CFG_CUT_BOTTOM: cut_bottom_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Intersection and classification of the incoming item.
    always_comb
    begin
        il = (in_left > cut_left_reg) ? in_left : cut_left_reg;
        it = (in_top > cut_top_reg) ? in_top : cut_top_reg;
        ir = (in_right < cut_right_reg) ? in_right : cut_right_reg;
        ib = (in_bottom < cut_bottom_reg) ? in_bottom : cut_bottom_reg;
        pass = (ir <= il) || (ib <= it);

        col_ne = {ir < in_right, 1'b1, in_left < il};
        row_ne = {ib < in_bottom, 1'b1, in_top < it};

        ent_next = '0;
        if (pass)
        begin
            // The source itself goes out as the single piece in column and row zero.
            ent_next.xs         = {in_right, in_right, in_right, in_left};
            ent_next.ys         = {in_bottom, in_bottom, in_bottom, in_top};
            ent_next.mask       = NUM_PIECES'(1);
            ent_next.overlapped = 1'b0;
        end
        else
        begin
            ent_next.xs         = {in_right, ir, il, in_left};
            ent_next.ys         = {in_bottom, ib, it, in_top};
            ent_next.overlapped = 1'b1;
            for (int p = 0; p < NUM_PIECES; p++)
            begin
                ent_next.mask[p] = col_ne[piece_col(PIECE_IDX_BITS'(p))]
                                 & row_ne[piece_row(PIECE_IDX_BITS'(p))];
            end
        end
        covered = !pass && (ent_next.mask == '0);
    end

    assign in_ready = !ent_valid_reg || ent_ready;

    // Output stage toward the queue; wholly covered items are dropped here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            ent_valid_reg <= in_valid && !covered;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            ent_reg <= ent_next;
        end
    end

    assign ent_valid = ent_valid_reg;
    assign ent       = ent_reg;

endmodule

/* sv/rsu_queue.sv */
module rsu_queue
    import rsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  rsu_entry_t push_data,
    output logic       pop_valid,
    input  logic       pop_ready,
    output rsu_entry_t pop_data
);

    rsu_entry_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_BITS-1:0] count_reg;
    logic                      push;
    logic                      pop;

    assign push_ready = (count_reg != QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers differ while empty");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a push");
`endif

endmodule

/* sv/rsu_back.sv */
module rsu_back
    import rsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pop_valid,
    output logic       pop_ready,
    input  rsu_entry_t pop_data,
    output logic       out_valid,
    input  logic       out_ready,
    output coord_t     piece_left,
    output coord_t     piece_top,
    output coord_t     piece_right,
    output coord_t     piece_bottom,
    output logic       overlapped,
    output logic       last_piece
);

    rsu_entry_t            cur_reg;
    logic [NUM_PIECES-1:0] rem_reg;
    logic                  busy_reg;
    logic                  out_valid_reg;
    coord_t                left_reg;
    coord_t                top_reg;
    coord_t                right_reg;
    coord_t                bottom_reg;
    logic                  ovl_reg;
    logic                  last_reg;

    logic                      advance;
    logic                      emit;
    logic                      pop;
    logic [PIECE_IDX_BITS-1:0] sel;
    logic [NUM_PIECES-1:0]     rem_after;
    logic                      last;
    logic [1:0]                col;
    logic [1:0]                row;
    logic [1:0]                col_hi;
    logic [1:0]                row_hi;

    // Lowest pending piece and its edges.
    always_comb
    begin
        sel = '0;
        for (int i = NUM_PIECES - 1; i >= 0; i--)
        begin
            if (rem_reg[i])
            begin
                sel = PIECE_IDX_BITS'(i);
            end
        end
        rem_after = rem_reg & ~(NUM_PIECES'(1) << sel);
        last      = (rem_after == '0);
        col       = piece_col(sel);
        row       = piece_row(sel);
        // Column and row indexes never exceed two, so the far edge index fits.
        col_hi    = col + 2'd1;
        row_hi    = row + 2'd1;
    end

    assign advance   = !out_valid_reg || out_ready;
    assign emit      = busy_reg && advance;
    assign pop_ready = !busy_reg || (emit && last);
    assign pop       = pop_valid && pop_ready;

    // Current item and the pieces still to send.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rem_reg  <= '0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
            rem_reg  <= pop_data.mask;
        end
        else if (emit)
        begin
            busy_reg <= !last;
            rem_reg  <= rem_after;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= pop_data;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            left_reg   <= cur_reg.xs[col];
            right_reg  <= cur_reg.xs[col_hi];
            top_reg    <= cur_reg.ys[row];
            bottom_reg <= cur_reg.ys[row_hi];
            ovl_reg    <= cur_reg.overlapped;
            last_reg   <= last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign piece_left   = left_reg;
    assign piece_top    = top_reg;
    assign piece_right  = right_reg;
    assign piece_bottom = bottom_reg;
    assign overlapped   = ovl_reg;
    assign last_piece   = last_reg;

`ifndef ASSERT_OFF
    a_busy_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg != '0))
        else $error("busy with no pieces left");

    a_pass_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !ovl_reg) |-> last_reg)
        else $error("pass-through item not marked last");

    a_pop_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !(emit && last)) |-> !pop)
        else $error("new item loaded over unfinished one");
`endif

endmodule

/* sv/rectangle_subtract_unit.sv */
// The first piece of an item passes the front output stage, a queue slot, the current
// item register of the back and the output register. The output gives one piece per cycle
// while out_ready is high; an item has 1 to 8 pieces; a wholly covered item is dropped.
// A two-entry queue decouples input classification from piece emission.
// Reset (rst_n, asynchronous, active low) clears the cut rectangle to zero and empties
// every stage; items in flight are discarded.
module rectangle_subtract_unit
    import rsu_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]   cfg_wdata,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  coord_t                  in_left,
    input  coord_t                  in_top,
    input  coord_t                  in_right,
    input  coord_t                  in_bottom,
    output logic                    out_valid,
    input  logic                    out_ready,
    output coord_t                  piece_left,
    output coord_t                  piece_top,
    output coord_t                  piece_right,
    output coord_t                  piece_bottom,
    output logic                    overlapped,
    output logic                    last_piece
);

    logic       ent_valid;
    logic       ent_ready;
    rsu_entry_t ent;
    logic       pop_valid;
    logic       pop_ready;
    rsu_entry_t pop_data;

    // Front: intersection and piece classification.
    rsu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_left   (in_left),
        .in_top    (in_top),
        .in_right  (in_right),
        .in_bottom (in_bottom),
        .ent_valid (ent_valid),
        .ent_ready (ent_ready),
        .ent       (ent)
    );

    // Queue of classified items.
    rsu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (ent_valid),
        .push_ready (ent_ready),
        .push_data  (ent),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Back: one piece per cycle into the output register while the output is not stalled.
    rsu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_data     (pop_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .piece_left   (piece_left),
        .piece_top    (piece_top),
        .piece_right  (piece_right),
        .piece_bottom (piece_bottom),
        .overlapped   (overlapped),
        .last_piece   (last_piece)
    );

endmodule
